FILE: src/frustum_box_point_cull_assert.svh
// Assertion macros shared by the frustum cull RTL.
`ifndef FRUSTUM_BOX_POINT_CULL_ASSERT_SVH
`define FRUSTUM_BOX_POINT_CULL_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FBPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FBPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/fbpc_pkg.sv
// Shared types and constants of the frustum cull block.
`timescale 1ns / 1ps
`default_nettype none
package fbpc_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int VAL_W  = 32;
  localparam int COMP_W = VAL_W + 1;
  localparam int PROD_W = COMP_W + VAL_W;
  localparam int ACC_W  = PROD_W + 2;

  typedef enum logic [1:0] {
    REQ_LOAD_ROW    = 2'd0,
    REQ_LOAD_CORNER = 2'd1,
    REQ_POINT       = 2'd2,
    REQ_BOX         = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    VERD_VISIBLE = 2'd0,
    VERD_BEHIND  = 2'd1,
    VERD_OUTSIDE = 2'd2,
    VERD_LOADED  = 2'd3
  } verdict_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DOT  = 2'd1,
    ST_AXIS = 2'd2,
    ST_DONE = 2'd3
  } state_t;

  typedef struct packed {
    logic mul_en;
    logic acc_clr;
    logic acc_en;
  } mac_ctl_t;

endpackage
`default_nettype wire

FILE: src/fbpc_mac.sv
// Shared multiply-accumulate unit for the plane dot products.
`timescale 1ns / 1ps
`default_nettype none
`include "frustum_box_point_cull_assert.svh"
module fbpc_mac (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire fbpc_pkg::mac_ctl_t                        ctl,
  input  wire logic signed [fbpc_pkg::COMP_W-1:0]        opa,
  input  wire logic signed [fbpc_pkg::VAL_W-1:0]         opb,
  output logic                                           dot_neg
);

  logic signed [fbpc_pkg::PROD_W-1:0] prod_r;
  logic signed [fbpc_pkg::ACC_W-1:0]  acc_r;
  logic signed [fbpc_pkg::ACC_W-1:0]  sum;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= opa * opb;
    end
    if (ctl.acc_clr) begin
      acc_r <= '0;
    end else if (ctl.acc_en) begin
      acc_r <= sum;
    end
  end

  // The last product is folded in combinationally to give the sign.
  assign sum     = acc_r + fbpc_pkg::ACC_W'(prod_r);
  assign dot_neg = sum[fbpc_pkg::ACC_W-1];

  `FBPC_ASSERT_NOW(a_ctl_excl, ctl.acc_clr, !ctl.acc_en, "mac clear and accumulate together")

endmodule
`default_nettype wire

FILE: src/frustum_box_point_cull.sv
// Top level of the frustum cull block: storage, sequencer and corner compare.
// Usage: items enter on the in_ channel (valid/ready); each gives one result
// on the out_ channel (visible, verdict). Loads write a matrix row or a
// frustum corner and raise out_valid with verdict 3 through the DONE state.
// Queries run on one shared multiplier: each plane dot product is four
// products and a sign test. A point query runs one dot per plane, stopping
// at the first plane it is behind, then loads the output register.
// A box query tests all eight box corners against each of the six planes,
// then compares the frustum corners to the box bounds on each of the three
// axes, and stops early on a cull. One request is worked on at a time;
// in_ready is high only while idle, from the edge that loads the output
// register on. A finished result sits in the output register until taken;
// when the receiver stalls the block can still take one new request, but
// holds the next result and takes no more requests till the first is taken.
// Synchronous active-low reset clears matrix rows and corners to zero,
// so every plane is zero and culls nothing until loaded.
`timescale 1ns / 1ps
`default_nettype none
`include "frustum_box_point_cull_assert.svh"
module frustum_box_point_cull #(
  parameter int FRAC_BITS = fbpc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [1:0]                         in_req_type,
  input  wire logic [2:0]                         in_slot,
  input  wire logic signed [fbpc_pkg::VAL_W-1:0]  in_val_a,
  input  wire logic signed [fbpc_pkg::VAL_W-1:0]  in_val_b,
  input  wire logic signed [fbpc_pkg::VAL_W-1:0]  in_val_c,
  input  wire logic signed [fbpc_pkg::VAL_W-1:0]  in_val_d,
  input  wire logic signed [fbpc_pkg::VAL_W-1:0]  in_val_e,
  input  wire logic signed [fbpc_pkg::VAL_W-1:0]  in_val_f,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    out_visible,
  output logic [1:0]                              out_verdict
);

  localparam int VW = fbpc_pkg::VAL_W;
  localparam logic signed [VW-1:0] ONE = VW'(64'd1 << FRAC_BITS);

  fbpc_pkg::state_t   st_r, st_nxt;
  fbpc_pkg::verdict_t res_r, res_nxt;
  fbpc_pkg::mac_ctl_t mac_ctl;

  logic signed [VW-1:0] mrow_r [4][4];
  logic signed [VW-1:0] corn_r [8][3];
  logic signed [VW-1:0] lo_r [3];
  logic signed [VW-1:0] hi_r [3];

  logic [2:0] k_r, k_nxt, i_r, i_nxt, c_r, c_nxt;
  logic [1:0] ax_r, ax_nxt;
  logic       all_r, all_nxt, above_r, above_nxt, below_r, below_nxt;
  logic       box_r;
  logic       out_valid_r;
  fbpc_pkg::verdict_t out_verdict_r;

  logic       accept, dot_neg, dot_end, fin;
  logic [1:0] cc;
  logic signed [VW-1:0]                 w_comp, o_comp, pt, cv, lo_ax, hi_ax;
  logic signed [fbpc_pkg::COMP_W-1:0]   plane_comp;
  logic signed [VW:0]                   sums [3];
  logic [VW*6-1:0] in_vals;

  assign accept   = in_valid && in_ready;
  assign in_ready = (st_r == fbpc_pkg::ST_IDLE);
  assign in_vals  = {in_val_f, in_val_e, in_val_d, in_val_c, in_val_b, in_val_a};

  // Plane component: row W plus or minus the row chosen by the plane index.
  assign cc     = c_r[1:0];
  assign w_comp = mrow_r[3][cc];
  assign o_comp = mrow_r[k_r[2:1]][cc];
  assign plane_comp = k_r[0] ? (fbpc_pkg::COMP_W'(w_comp) - fbpc_pkg::COMP_W'(o_comp))
                             : (fbpc_pkg::COMP_W'(w_comp) + fbpc_pkg::COMP_W'(o_comp));

  always_comb begin
    case (cc)
      2'd0:    pt = i_r[0] ? hi_r[0] : lo_r[0];
      2'd1:    pt = i_r[1] ? hi_r[1] : lo_r[1];
      2'd2:    pt = i_r[2] ? hi_r[2] : lo_r[2];
      default: pt = ONE;
    endcase
  end

  always_comb begin
    case (ax_r)
      2'd0:    begin cv = corn_r[i_r][0]; lo_ax = lo_r[0]; hi_ax = hi_r[0]; end
      2'd1:    begin cv = corn_r[i_r][1]; lo_ax = lo_r[1]; hi_ax = hi_r[1]; end
      default: begin cv = corn_r[i_r][2]; lo_ax = lo_r[2]; hi_ax = hi_r[2]; end
    endcase
  end

  always_comb begin
    mac_ctl.mul_en  = (st_r == fbpc_pkg::ST_DOT) && (c_r != 3'd4);
    mac_ctl.acc_clr = (st_r == fbpc_pkg::ST_DOT) && (c_r == 3'd0);
    mac_ctl.acc_en  = (st_r == fbpc_pkg::ST_DOT) && (c_r != 3'd0) && (c_r != 3'd4);
  end

  fbpc_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mac_ctl),
    .opa     (plane_comp),
    .opb     (pt),
    .dot_neg (dot_neg)
  );

  assign dot_end = (st_r == fbpc_pkg::ST_DOT) && (c_r == 3'd4);

  // Sequencer counters, cull flags and the finishing verdict.
  always_comb begin
    k_nxt = k_r; i_nxt = i_r; c_nxt = c_r; ax_nxt = ax_r;
    all_nxt = all_r; above_nxt = above_r; below_nxt = below_r;
    res_nxt = res_r;
    fin = 1'b0;
    if (accept) begin
      k_nxt = '0; i_nxt = '0; c_nxt = '0; ax_nxt = '0;
      res_nxt = fbpc_pkg::VERD_LOADED;
    end else if (st_r == fbpc_pkg::ST_DOT) begin
      c_nxt = c_r + 3'd1;
      if (dot_end) begin
        c_nxt = '0;
        if (!box_r) begin
          if (dot_neg) begin
            fin = 1'b1; res_nxt = fbpc_pkg::VERD_BEHIND;
          end else if (k_r == 3'd5) begin
            fin = 1'b1; res_nxt = fbpc_pkg::VERD_VISIBLE;
          end else begin
            k_nxt = k_r + 3'd1;
          end
        end else begin
          all_nxt = ((i_r == 3'd0) || all_r) && dot_neg;
          i_nxt   = i_r + 3'd1;
          if (i_r == 3'd7) begin
            if (all_nxt) begin
              fin = 1'b1; res_nxt = fbpc_pkg::VERD_BEHIND;
            end else if (k_r == 3'd5) begin
              ax_nxt = '0;
            end else begin
              k_nxt = k_r + 3'd1;
            end
          end
        end
      end
    end else if (st_r == fbpc_pkg::ST_AXIS) begin
      above_nxt = ((i_r == 3'd0) || above_r) && (cv > hi_ax);
      below_nxt = ((i_r == 3'd0) || below_r) && (cv < lo_ax);
      i_nxt = i_r + 3'd1;
      if (i_r == 3'd7) begin
        if (above_nxt || below_nxt) begin
          fin = 1'b1; res_nxt = fbpc_pkg::VERD_OUTSIDE;
        end else if (ax_r == 2'd2) begin
          fin = 1'b1; res_nxt = fbpc_pkg::VERD_VISIBLE;
        end else begin
          ax_nxt = ax_r + 2'd1;
        end
      end
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      fbpc_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_req_type == fbpc_pkg::REQ_POINT || in_req_type == fbpc_pkg::REQ_BOX) begin
            st_nxt = fbpc_pkg::ST_DOT;
          end else begin
            st_nxt = fbpc_pkg::ST_DONE;
          end
        end
      end
      fbpc_pkg::ST_DOT: begin
        if (fin) begin
          st_nxt = fbpc_pkg::ST_DONE;
        end else if (dot_end && box_r && i_r == 3'd7 && k_r == 3'd5) begin
          st_nxt = fbpc_pkg::ST_AXIS;
        end
      end
      fbpc_pkg::ST_AXIS: begin
        if (fin) begin
          st_nxt = fbpc_pkg::ST_DONE;
        end
      end
      fbpc_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          st_nxt = fbpc_pkg::ST_IDLE;
        end
      end
      default: st_nxt = fbpc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= fbpc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      k_r <= '0; i_r <= '0; c_r <= '0; ax_r <= '0;
      all_r <= 1'b0; above_r <= 1'b0; below_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      k_r <= k_nxt; i_r <= i_nxt; c_r <= c_nxt; ax_r <= ax_nxt;
      all_r <= all_nxt; above_r <= above_nxt; below_r <= below_nxt;
      if (st_r == fbpc_pkg::ST_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (st_r == fbpc_pkg::ST_DONE && (!out_valid_r || out_ready)) begin
      out_verdict_r <= res_r;
    end
  end

  // Box maximum is origin plus size, clamped to the 32-bit range.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sums[a] = (VW+1)'(signed'(in_vals[a*VW +: VW]))
              + (VW+1)'(signed'(in_vals[(a+3)*VW +: VW]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          mrow_r[r][c] <= '0;
        end
      end
      for (int n = 0; n < 8; n++) begin
        for (int a = 0; a < 3; a++) begin
          corn_r[n][a] <= '0;
        end
      end
    end else if (accept) begin
      if (in_req_type == fbpc_pkg::REQ_LOAD_ROW && !in_slot[2]) begin
        for (int c = 0; c < 4; c++) begin
          mrow_r[in_slot[1:0]][c] <= in_vals[c*VW +: VW];
        end
      end
      if (in_req_type == fbpc_pkg::REQ_LOAD_CORNER) begin
        for (int a = 0; a < 3; a++) begin
          corn_r[in_slot][a] <= in_vals[a*VW +: VW];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      box_r <= (in_req_type == fbpc_pkg::REQ_BOX);
      for (int a = 0; a < 3; a++) begin
        lo_r[a] <= in_vals[a*VW +: VW];
        if (sums[a][VW] != sums[a][VW-1]) begin
          hi_r[a] <= sums[a][VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
        end else begin
          hi_r[a] <= sums[a][VW-1:0];
        end
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;
  assign out_visible = (out_verdict_r == fbpc_pkg::VERD_VISIBLE) ||
                       (out_verdict_r == fbpc_pkg::VERD_LOADED);

  `FBPC_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready, "ready after accepting a request")
  `FBPC_ASSERT_NOW(a_dot_counters, st_r == fbpc_pkg::ST_DOT, (k_r <= 3'd5) && (c_r <= 3'd4), "dot counters out of range")
  `FBPC_ASSERT_NOW(a_point_verdict, (st_r == fbpc_pkg::ST_DONE) && !box_r && (res_r != fbpc_pkg::VERD_LOADED), res_r != fbpc_pkg::VERD_OUTSIDE, "point query gave corner-bound verdict")
  `FBPC_ASSERT_NOW(a_axis_only_box, st_r == fbpc_pkg::ST_AXIS, box_r && (ax_r <= 2'd2), "corner compare outside a box query")

endmodule
`default_nettype wire

FILE: test/fbpc_checker.sv
// Checker for the frustum cull block: predicts each request's result and compares.
`timescale 1ns / 1ps
module fbpc_checker
  import fbpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        in_req_type,
  input  logic [2:0]        in_slot,
  input  logic signed [31:0] in_val_a,
  input  logic signed [31:0] in_val_b,
  input  logic signed [31:0] in_val_c,
  input  logic signed [31:0] in_val_d,
  input  logic signed [31:0] in_val_e,
  input  logic signed [31:0] in_val_f,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              out_visible,
  input  logic [1:0]        out_verdict,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    logic     visible;
    verdict_t verdict;
  } cull_result_t;

  logic signed [31:0] rows [16];
  logic signed [31:0] corners [24];
  cull_result_t       expected_q [$];

  // Plane k is row W plus (k even) or minus (k odd) row k/2; exact wide dot.
  function automatic bit behind_plane(int k, logic signed [31:0] x,
                                      logic signed [31:0] y, logic signed [31:0] z);
    logic signed [69:0] acc, n, w, o, p;
    acc = '0;
    for (int c = 0; c < 4; c++) begin
      w = 70'(rows[12 + c]);
      o = 70'(rows[(k >> 1) * 4 + c]);
      n = (k & 1) ? w - o : w + o;
      case (c)
        0: p = 70'(x);
        1: p = 70'(y);
        2: p = 70'(z);
        default: p = 70'sd1 <<< FRAC_BITS_DEF;
      endcase
      acc = acc + n * p;
    end
    return acc < 0;
  endfunction

  function automatic verdict_t predict_cull(req_t kind, logic signed [31:0] v [6]);
    logic signed [31:0] lo [3], hi [3];
    logic signed [33:0] s;
    int n_out, above, below;
    if (kind == REQ_POINT) begin
      for (int k = 0; k < 6; k++)
        if (behind_plane(k, v[0], v[1], v[2])) return VERD_BEHIND;
      return VERD_VISIBLE;
    end
    for (int i = 0; i < 3; i++) begin
      lo[i] = v[i];
      s = 34'(v[i]) + 34'(v[3 + i]);
      if (s > 34'sh7fffffff) hi[i] = 32'sh7fffffff;
      else if (s < -34'sh80000000) hi[i] = 32'sh80000000;
      else hi[i] = s[31:0];
    end
    for (int k = 0; k < 6; k++) begin
      n_out = 0;
      for (int i = 0; i < 8; i++)
        n_out += behind_plane(k, (i & 1) ? hi[0] : lo[0], (i & 2) ? hi[1] : lo[1],
                              (i & 4) ? hi[2] : lo[2]);
      if (n_out == 8) return VERD_BEHIND;
    end
    for (int ax = 0; ax < 3; ax++) begin
      above = 0;
      below = 0;
      for (int i = 0; i < 8; i++) begin
        if (corners[i * 3 + ax] > hi[ax]) above++;
        if (corners[i * 3 + ax] < lo[ax]) below++;
      end
      if (above == 8 || below == 8) return VERD_OUTSIDE;
    end
    return VERD_VISIBLE;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    logic signed [31:0] v [6];
    cull_result_t exp_r;
    if (!rst_n) begin
      foreach (rows[i]) rows[i] = '0;
      foreach (corners[i]) corners[i] = '0;
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result: visible %0d verdict %0d",
                                        out_visible, out_verdict);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (out_visible !== exp_r.visible || out_verdict !== exp_r.verdict) begin
            if (fail_count < 10)
              $display("mismatch: expected visible %0d verdict %0d, got visible %0d verdict %0d",
                       exp_r.visible, exp_r.verdict, out_visible, out_verdict);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        v = '{in_val_a, in_val_b, in_val_c, in_val_d, in_val_e, in_val_f};
        exp_r.verdict = VERD_LOADED;
        case (req_t'(in_req_type))
          REQ_LOAD_ROW: begin
            // Writes to rows 4..7 are dropped but still acknowledged.
            if (in_slot < 4)
              for (int i = 0; i < 4; i++) rows[in_slot * 4 + i] = v[i];
          end
          REQ_LOAD_CORNER: begin
            for (int i = 0; i < 3; i++) corners[in_slot * 3 + i] = v[i];
          end
          default: exp_r.verdict = predict_cull(req_t'(in_req_type), v);
        endcase
        exp_r.visible = (exp_r.verdict == VERD_VISIBLE || exp_r.verdict == VERD_LOADED);
        expected_q.push_back(exp_r);
      end
    end
  end

endmodule

FILE: test/tb_frustum_box_point_cull.sv
// Testbench top for the frustum cull block: stimulus, handshake pressure and verdict.
`timescale 1ns / 1ps
module tb_frustum_box_point_cull;
  import fbpc_pkg::*;

  localparam logic signed [31:0] ONE = 32'sh10000;
  localparam logic signed [31:0] VMAX = 32'sh7fffffff;
  localparam logic signed [31:0] VMIN = 32'sh80000000;
  localparam int N_ITEMS = 900;
  localparam int WATCHDOG_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_req_type = '0;
  logic [2:0] in_slot = '0;
  logic signed [31:0] in_val_a = '0, in_val_b = '0, in_val_c = '0;
  logic signed [31:0] in_val_d = '0, in_val_e = '0, in_val_f = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_visible;
  logic [1:0] out_verdict;
  int fail_count, pending;
  int sent = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit quiet = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  frustum_box_point_cull i_dut (.*);

  fbpc_checker i_checker (.*);

  // Receiver side: random stall bursts, none near the end of the run.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!quiet && rst_n && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 6);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic signed [31:0] jitter(int span);
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic send(req_t kind, logic [2:0] slot, logic signed [31:0] a,
                      logic signed [31:0] b, logic signed [31:0] c,
                      logic signed [31:0] d, logic signed [31:0] e,
                      logic signed [31:0] f);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= kind;
    in_slot <= slot;
    in_val_a <= a;
    in_val_b <= b;
    in_val_c <= c;
    in_val_d <= d;
    in_val_e <= e;
    in_val_f <= f;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // A near-identity view matrix and a jittered box of frustum corners.
  task automatic load_scene();
    logic signed [31:0] r [4];
    logic signed [31:0] off [3];
    for (int row = 0; row < 4; row++) begin
      for (int c = 0; c < 4; c++) r[c] = (c == row ? ONE : 0) + jitter(ONE / 4);
      send(REQ_LOAD_ROW, 3'(row), r[0], r[1], r[2], r[3], $urandom, $urandom);
    end
    for (int ax = 0; ax < 3; ax++)
      off[ax] = ($urandom_range(0, 2) == 0) ? jitter(4 * ONE) : 0;
    for (int i = 0; i < 8; i++)
      send(REQ_LOAD_CORNER, 3'(i), off[0] + jitter(3 * ONE / 2), off[1] + jitter(3 * ONE / 2),
           off[2] + jitter(3 * ONE / 2), $urandom, $urandom, $urandom);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero planes cull nothing; all-zero corners make a positive box fall outside.
    send(REQ_POINT, 0, VMAX, VMIN, 0, 0, 0, 0);
    send(REQ_BOX, 0, ONE, ONE, ONE, ONE, ONE, ONE);
    send(REQ_BOX, 0, -ONE, -ONE, -ONE, 2 * ONE, 2 * ONE, 2 * ONE);
    send(REQ_LOAD_ROW, 5, VMAX, VMAX, VMAX, VMAX, VMAX, VMAX);
    send(REQ_POINT, 7, VMIN, VMIN, VMIN, VMIN, VMIN, VMIN);
    send(REQ_LOAD_ROW, 0, ONE, 0, 0, 0, 0, 0);
    send(REQ_LOAD_ROW, 1, 0, ONE, 0, 0, 0, 0);
    send(REQ_LOAD_ROW, 2, 0, 0, ONE, 0, 0, 0);
    send(REQ_LOAD_ROW, 3, 0, 0, 0, ONE, 0, 0);
    for (int i = 0; i < 8; i++)
      send(REQ_LOAD_CORNER, 3'(i), (i & 1) ? ONE : -ONE, (i & 2) ? ONE : -ONE,
           (i & 4) ? ONE : -ONE, 0, 0, 0);
    send(REQ_POINT, 0, 0, 0, 0, 0, 0, 0);
    send(REQ_POINT, 0, 2 * ONE, 0, 0, 0, 0, 0);
    send(REQ_BOX, 0, VMAX, VMAX, VMAX, VMAX, VMAX, VMAX);
    send(REQ_BOX, 0, VMIN, VMIN, VMIN, VMIN, VMIN, VMIN);
    // Negative size keeps origin as the minimum, leaving an empty-looking box.
    send(REQ_BOX, 0, ONE / 2, ONE / 2, ONE / 2, -ONE, -ONE, -ONE);
    send(REQ_LOAD_ROW, 3, VMIN, VMAX, VMIN, VMAX, 0, 0);
    send(REQ_POINT, 0, VMIN, VMAX, VMIN, 0, 0, 0);

    while (sent < N_ITEMS) begin
      if (sent > N_ITEMS - 100) quiet = 1'b1;
      case ($urandom_range(0, 19))
        0, 1: send(req_t'($urandom_range(0, 3)), 3'($urandom), $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom);
        2: load_scene();
        3, 4, 5, 6, 7, 8, 9, 10:
          send(REQ_POINT, 3'($urandom), jitter(2 * ONE), jitter(2 * ONE), jitter(2 * ONE),
               $urandom, $urandom, $urandom);
        default:
          send(REQ_BOX, 3'($urandom), jitter(3 * ONE), jitter(3 * ONE), jitter(3 * ONE),
               jitter(2 * ONE), jitter(2 * ONE), jitter(2 * ONE));
      endcase
    end
    in_valid <= 1'b0;

    // Let the checker take in the last request before looking at the queue.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/fbpc_pkg.sv
src/fbpc_mac.sv
src/frustum_box_point_cull.sv
test/fbpc_checker.sv
test/tb_frustum_box_point_cull.sv
